FILE: design/qpr_pkg.sv
// Package with the shared types, constants and helper functions of the quaternion retarget block.
package qpr_pkg;

    localparam int COMP_W      = 16;
    localparam int FRAC_BITS   = 14;
    localparam int REG_FIELD_W = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int QW          = FRAC_BITS + 2;
    localparam int SUM_W       = 2 * QW + 2;
    localparam int ROOT_STEPS  = 32;
    localparam int LEN_W       = 31;

    localparam logic [63:0] BIG_MAG   = 64'd1 << 30;
    localparam logic [63:0] INV_LIMIT =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd99999999) / 64'd100000000;
    localparam logic [CFG_DATA_W-1:0] CFG_RESET = 64'h4000_0000_0000_0000;
    localparam logic [QW-1:0]     Q_ONE   = QW'(1 << FRAC_BITS);
    localparam logic [COMP_W-1:0] OUT_ONE = COMP_W'(1 << FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_REST = 3'd0,
        REG_TGT_REST = 3'd1,
        REG_SRC_OFF  = 3'd2,
        REG_TGT_OFF  = 3'd3,
        REG_AXIS     = 3'd4
    } qpr_reg_idx_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] in_w;
        logic signed [COMP_W-1:0] in_z;
        logic signed [COMP_W-1:0] in_y;
        logic signed [COMP_W-1:0] in_x;
    } qpr_in_t;

    typedef struct packed {
        logic                     invalid_input;
        logic signed [COMP_W-1:0] out_w;
        logic signed [COMP_W-1:0] out_z;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_x;
    } qpr_out_t;

    function automatic int norm_lat(input int w);
        return $clog2(w) + FRAC_BITS + 38;
    endfunction

    localparam int MUL_LAT = 2 + norm_lat(SUM_W);

    function automatic logic [3:0][QW-1:0] qconj(input logic [3:0][QW-1:0] q);
        logic [3:0][QW-1:0] r;
        r    = q;
        r[0] = -q[0];
        r[1] = -q[1];
        r[2] = -q[2];
        return r;
    endfunction

endpackage

FILE: design/qpr_check.sv
// Front stages that flag input quaternions whose length is below the threshold.
module qpr_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [3:0][qpr_pkg::COMP_W-1:0]   in_raw,
    output logic                              out_valid,
    output logic                              out_invalid,
    output logic [3:0][qpr_pkg::COMP_W-1:0]   out_raw
);
    localparam int CW = qpr_pkg::COMP_W;

    logic [3:0][CW-1:0]   mag;
    logic                 big;
    logic                 v1_reg;
    logic                 big1_reg;
    logic [3:0][CW-1:0]   raw1_reg;
    logic [3:0][2*CW-1:0] sq1_reg;
    logic [63:0]          sq_sum;
    logic                 v2_reg;
    logic                 inv2_reg;
    logic [3:0][CW-1:0]   raw2_reg;

    always_comb
    begin
        big = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = in_raw[i][CW-1] ? (~in_raw[i] + 1'b1) : in_raw[i];
            if (64'(mag[i]) >= qpr_pkg::BIG_MAG)
            begin
                big = 1'b1;
            end
        end
        sq_sum = 64'(sq1_reg[0]) + 64'(sq1_reg[1]) + 64'(sq1_reg[2]) + 64'(sq1_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw1_reg <= in_raw;
            big1_reg <= big;
            for (int i = 0; i < 4; i++)
            begin
                sq1_reg[i] <= (2*CW)'(mag[i]) * (2*CW)'(mag[i]);
            end
            raw2_reg <= raw1_reg;
            inv2_reg <= !big1_reg && (sq_sum < qpr_pkg::INV_LIMIT);
        end
    end

    assign out_valid   = v2_reg;
    assign out_invalid = inv2_reg;
    assign out_raw     = raw2_reg;

endmodule

FILE: design/qpr_norm.sv
// Pipelined quaternion normalizer: scaling shift, integer square root and per-component division.
module qpr_norm #(
    parameter int W = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          in_tag,
    input  logic [3:0][W-1:0]             in_q,
    output logic                          out_valid,
    output logic                          out_tag,
    output logic [3:0][qpr_pkg::QW-1:0]   out_q
);
    localparam int FB   = qpr_pkg::FRAC_BITS;
    localparam int QW   = qpr_pkg::QW;
    localparam int NSH  = $clog2(W);
    localparam int LAT  = qpr_pkg::norm_lat(W);
    localparam int SQS  = qpr_pkg::ROOT_STEPS;
    localparam int LW   = qpr_pkg::LEN_W;
    localparam int NUMW = LW + FB;
    localparam int DVS  = FB + 1;

    typedef struct packed {
        logic       tag;
        logic       zero;
        logic [3:0] neg;
    } side_t;

    side_t                side_in;
    logic [LAT-1:0]       valid_reg;
    side_t                side_reg [LAT];
    logic [3:0][W-1:0]    sh_reg [NSH+1];
    logic [3:0][29:0]     a30;
    logic [3:0][59:0]     sq_reg;
    logic [3:0][29:0]     sqa_reg;
    logic [62:0]          rem_reg  [SQS];
    logic [62:0]          root_reg [SQS+1];
    logic [3:0][29:0]     ra_reg   [SQS+1];
    logic [LW-1:0]        len;
    logic [3:0][NUMW-1:0] num_reg  [DVS];
    logic [LW-1:0]        den_reg  [DVS];
    logic [3:0][FB:0]     quo_reg  [DVS+1];
    logic [3:0][QW-1:0]   out_reg;

    always_comb
    begin
        side_in.tag  = in_tag;
        side_in.zero = (in_q == '0);
        for (int i = 0; i < 4; i++)
        begin
            side_in.neg[i] = in_q[i][W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int p = 1; p < LAT; p++)
            begin
                side_reg[p] <= side_reg[p-1];
            end
            for (int i = 0; i < 4; i++)
            begin
                sh_reg[0][i] <= in_q[i][W-1] ? (~in_q[i] + 1'b1) : in_q[i];
            end
        end
    end

    for (genvar k = 0; k < NSH; k++)
    begin : g_shift
        localparam int SA = 1 << (NSH - 1 - k);
        logic [W-1:0] orv;
        assign orv = sh_reg[k][0] | sh_reg[k][1] | sh_reg[k][2] | sh_reg[k][3];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    sh_reg[k+1][i] <= (orv[W-1 -: SA] == '0) ? (sh_reg[k][i] << SA)
                                                             : sh_reg[k][i];
                end
            end
        end
    end

    if (W >= 30)
    begin : g_top_wide
        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                a30[i] = sh_reg[NSH][i][W-1 -: 30];
            end
        end
    end
    else
    begin : g_top_narrow
        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                a30[i] = {sh_reg[NSH][i], {(30-W){1'b0}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i] <= 60'(a30[i]) * 60'(a30[i]);
            end
            sqa_reg     <= a30;
            rem_reg[0]  <= 63'(sq_reg[0]) + 63'(sq_reg[1]) + 63'(sq_reg[2]) + 63'(sq_reg[3]);
            root_reg[0] <= '0;
            ra_reg[0]   <= sqa_reg;
        end
    end

    for (genvar t = 0; t < SQS; t++)
    begin : g_root
        localparam logic [62:0] BIT = 63'd1 << (62 - 2 * t);
        logic [62:0] trial;
        logic        ge;
        assign trial = root_reg[t] + BIT;
        assign ge    = (rem_reg[t] >= trial);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[t+1] <= ge ? ((root_reg[t] >> 1) + BIT) : (root_reg[t] >> 1);
                ra_reg[t+1]   <= ra_reg[t];
            end
        end
        if (t < SQS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[t+1] <= ge ? (rem_reg[t] - trial) : rem_reg[t];
                end
            end
        end
    end

    assign len = root_reg[SQS][LW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                num_reg[0][i] <= (NUMW'(ra_reg[SQS][i]) << FB) + NUMW'(len >> 1);
            end
            den_reg[0] <= len;
            quo_reg[0] <= '0;
        end
    end

    for (genvar u = 0; u < DVS; u++)
    begin : g_div
        logic [NUMW-1:0] dsh;
        logic [3:0]      ge;
        assign dsh = NUMW'(den_reg[u]) << (FB - u);
        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                ge[i] = (num_reg[u][i] >= dsh);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    quo_reg[u+1][i] <= {quo_reg[u][i][FB-1:0], ge[i]};
                end
            end
        end
        if (u < DVS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[u+1] <= den_reg[u];
                    for (int i = 0; i < 4; i++)
                    begin
                        num_reg[u+1][i] <= ge[i] ? (num_reg[u][i] - dsh) : num_reg[u][i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (side_reg[LAT-2].zero)
                begin
                    out_reg[i] <= (i == 3) ? qpr_pkg::Q_ONE : '0;
                end
                else if (side_reg[LAT-2].neg[i])
                begin
                    out_reg[i] <= -QW'(quo_reg[DVS][i]);
                end
                else
                begin
                    out_reg[i] <= QW'(quo_reg[DVS][i]);
                end
            end
        end
    end

    assign out_valid = valid_reg[LAT-1];
    assign out_tag   = side_reg[LAT-1].tag;
    assign out_q     = out_reg;

endmodule

FILE: design/qpr_qmul.sv
// Pipelined Hamilton product of two quaternions followed by normalization.
module qpr_qmul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          in_tag,
    input  logic [3:0][qpr_pkg::QW-1:0]   a,
    input  logic [3:0][qpr_pkg::QW-1:0]   b,
    output logic                          out_valid,
    output logic                          out_tag,
    output logic [3:0][qpr_pkg::QW-1:0]   out_q
);
    localparam int QW = qpr_pkg::QW;
    localparam int PW = 2 * QW;
    localparam int SW = qpr_pkg::SUM_W;

    logic signed [PW-1:0] prod_reg [4][4];
    logic                 v1_reg;
    logic                 t1_reg;
    logic [3:0][SW-1:0]   sum_reg;
    logic                 v2_reg;
    logic                 t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= in_tag;
            t2_reg <= t1_reg;
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_reg[i][j] <= PW'($signed(a[i])) * PW'($signed(b[j]));
                end
            end
            sum_reg[3] <= SW'(prod_reg[3][3]) - SW'(prod_reg[0][0])
                        - SW'(prod_reg[1][1]) - SW'(prod_reg[2][2]);
            sum_reg[0] <= SW'(prod_reg[3][0]) + SW'(prod_reg[0][3])
                        + SW'(prod_reg[1][2]) - SW'(prod_reg[2][1]);
            sum_reg[1] <= SW'(prod_reg[3][1]) - SW'(prod_reg[0][2])
                        + SW'(prod_reg[1][3]) + SW'(prod_reg[2][0]);
            sum_reg[2] <= SW'(prod_reg[3][2]) + SW'(prod_reg[0][1])
                        - SW'(prod_reg[1][0]) + SW'(prod_reg[2][3]);
        end
    end

    qpr_norm #(
        .W (SW)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_tag    (t2_reg),
        .in_q      (sum_reg),
        .out_valid (out_valid),
        .out_tag   (out_tag),
        .out_q     (out_q)
    );

endmodule

FILE: design/quaternion_pose_retarget.sv
// Top level of the quaternion rest-pose delta retarget pipeline.
//
//  channel   direction  handshake                 word
//  in        input      in_valid / in_ready        qpr_in_t  (in_x, in_y, in_z, in_w)
//  out       output     out_valid / out_ready      qpr_out_t (out_x..out_w, invalid_input)
//  cfg       input      cfg_we                     cfg_index, cfg_data
//
// One word is accepted per cycle while in_ready is high; the pipeline depth is set by
// the seven pipelined normalizers (square root and division one bit per stage).
// The whole pipeline advances together and freezes while the output word waits.
// After reset and after every configuration write, in_ready stays low while
// the normalized configuration quaternions are recomputed.
module quaternion_pose_retarget (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  qpr_pkg::qpr_in_t                     in_word,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output qpr_pkg::qpr_out_t                    out_word,
    input  logic                                 cfg_we,
    input  logic [qpr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [qpr_pkg::CFG_DATA_W-1:0]       cfg_data
);
    localparam int QW      = qpr_pkg::QW;
    localparam int CW      = qpr_pkg::COMP_W;
    localparam int FW      = qpr_pkg::REG_FIELD_W;
    localparam int CFG_LAT = qpr_pkg::norm_lat(FW) + qpr_pkg::MUL_LAT;
    localparam int SETW    = $clog2(CFG_LAT + 1);
    localparam longint SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam longint SAT_LO = -SAT_HI - 64'sd1;

    logic [3:0][FW-1:0]  cfg_reg [5];
    logic [SETW-1:0]     settle_reg;
    logic                en;
    logic [3:0][CW-1:0]  in_raw;

    logic [3:0][QW-1:0]  so_q, to_q, ax_q, srn_q, trn_q, sr_q, tr_q;

    logic                chk_valid, chk_inv;
    logic [3:0][CW-1:0]  chk_raw;
    logic                n0_valid, n0_tag;
    logic [3:0][QW-1:0]  n0_q;
    logic [6:0]          m_valid, m_tag;
    logic [3:0][QW-1:0]  m_q [7];

    logic [3:0][CW-1:0]  sat;
    qpr_pkg::qpr_out_t   out_next;
    qpr_pkg::qpr_out_t   out_word_reg;
    logic                out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en && (settle_reg == '0);
    assign in_raw   = {in_word.in_w, in_word.in_z, in_word.in_y, in_word.in_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 5; k++)
            begin
                cfg_reg[k] <= qpr_pkg::CFG_RESET;
            end
            settle_reg <= SETW'(CFG_LAT);
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index <= qpr_pkg::REG_AXIS)
                begin
                    cfg_reg[cfg_index] <= cfg_data;
                end
                settle_reg <= SETW'(CFG_LAT);
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - 1'b1;
            end
        end
    end

    // Configuration lanes run freely; their outputs are constant once settled.
    qpr_norm #(.W(FW)) u_norm_so (
        .clk(clk), .rst_n(rst_n), .en(1'b1), .in_valid(1'b1), .in_tag(1'b0),
        .in_q(cfg_reg[qpr_pkg::REG_SRC_OFF]), .out_valid(), .out_tag(), .out_q(so_q)
    );
    qpr_norm #(.W(FW)) u_norm_to (
        .clk(clk), .rst_n(rst_n), .en(1'b1), .in_valid(1'b1), .in_tag(1'b0),
        .in_q(cfg_reg[qpr_pkg::REG_TGT_OFF]), .out_valid(), .out_tag(), .out_q(to_q)
    );
    qpr_norm #(.W(FW)) u_norm_ax (
        .clk(clk), .rst_n(rst_n), .en(1'b1), .in_valid(1'b1), .in_tag(1'b0),
        .in_q(cfg_reg[qpr_pkg::REG_AXIS]), .out_valid(), .out_tag(), .out_q(ax_q)
    );
    qpr_norm #(.W(FW)) u_norm_sr (
        .clk(clk), .rst_n(rst_n), .en(1'b1), .in_valid(1'b1), .in_tag(1'b0),
        .in_q(cfg_reg[qpr_pkg::REG_SRC_REST]), .out_valid(), .out_tag(), .out_q(srn_q)
    );
    qpr_norm #(.W(FW)) u_norm_tr (
        .clk(clk), .rst_n(rst_n), .en(1'b1), .in_valid(1'b1), .in_tag(1'b0),
        .in_q(cfg_reg[qpr_pkg::REG_TGT_REST]), .out_valid(), .out_tag(), .out_q(trn_q)
    );
    qpr_qmul u_mul_sr (
        .clk(clk), .rst_n(rst_n), .en(1'b1), .in_valid(1'b1), .in_tag(1'b0),
        .a(srn_q), .b(so_q), .out_valid(), .out_tag(), .out_q(sr_q)
    );
    qpr_qmul u_mul_tr (
        .clk(clk), .rst_n(rst_n), .en(1'b1), .in_valid(1'b1), .in_tag(1'b0),
        .a(trn_q), .b(to_q), .out_valid(), .out_tag(), .out_q(tr_q)
    );

    qpr_check u_check (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid && (settle_reg == '0)),
        .in_raw(in_raw), .out_valid(chk_valid), .out_invalid(chk_inv), .out_raw(chk_raw)
    );

    qpr_norm #(.W(CW)) u_norm_in (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(chk_valid), .in_tag(chk_inv),
        .in_q(chk_raw), .out_valid(n0_valid), .out_tag(n0_tag), .out_q(n0_q)
    );

    assign m_valid[0] = n0_valid;
    assign m_tag[0]   = n0_tag;
    assign m_q[0]     = n0_q;

    qpr_qmul u_mul_sc (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_valid[0]), .in_tag(m_tag[0]),
        .a(m_q[0]), .b(so_q), .out_valid(m_valid[1]), .out_tag(m_tag[1]), .out_q(m_q[1])
    );
    qpr_qmul u_mul_d (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_valid[1]), .in_tag(m_tag[1]),
        .a(qpr_pkg::qconj(sr_q)), .b(m_q[1]),
        .out_valid(m_valid[2]), .out_tag(m_tag[2]), .out_q(m_q[2])
    );
    qpr_qmul u_mul_axd (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_valid[2]), .in_tag(m_tag[2]),
        .a(ax_q), .b(m_q[2]), .out_valid(m_valid[3]), .out_tag(m_tag[3]), .out_q(m_q[3])
    );
    qpr_qmul u_mul_cd (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_valid[3]), .in_tag(m_tag[3]),
        .a(m_q[3]), .b(qpr_pkg::qconj(ax_q)),
        .out_valid(m_valid[4]), .out_tag(m_tag[4]), .out_q(m_q[4])
    );
    qpr_qmul u_mul_trcd (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_valid[4]), .in_tag(m_tag[4]),
        .a(tr_q), .b(m_q[4]), .out_valid(m_valid[5]), .out_tag(m_tag[5]), .out_q(m_q[5])
    );
    qpr_qmul u_mul_res (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_valid[5]), .in_tag(m_tag[5]),
        .a(m_q[5]), .b(qpr_pkg::qconj(to_q)),
        .out_valid(m_valid[6]), .out_tag(m_tag[6]), .out_q(m_q[6])
    );

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (longint'($signed(m_q[6][i])) > SAT_HI)
            begin
                sat[i] = CW'(SAT_HI);
            end
            else if (longint'($signed(m_q[6][i])) < SAT_LO)
            begin
                sat[i] = CW'(SAT_LO);
            end
            else
            begin
                sat[i] = CW'($signed(m_q[6][i]));
            end
        end
        out_next.invalid_input = m_tag[6];
        if (m_tag[6])
        begin
            out_next.out_x = '0;
            out_next.out_y = '0;
            out_next.out_z = '0;
            out_next.out_w = qpr_pkg::OUT_ONE;
        end
        else
        begin
            out_next.out_x = sat[0];
            out_next.out_y = sat[1];
            out_next.out_z = sat[2];
            out_next.out_w = sat[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= m_valid[6];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_word_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: design/qpr_checker.sv
// Port-level assertions for the quaternion retarget block and the bind that attaches them.
module qpr_assertions (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input qpr_pkg::qpr_out_t               out_word,
    input logic                            cfg_we
);
    localparam int UNIT = 1 << qpr_pkg::FRAC_BITS;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    a_invalid_identity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.invalid_input |->
            out_word.out_x == '0 && out_word.out_y == '0 && out_word.out_z == '0 &&
            out_word.out_w == qpr_pkg::OUT_ONE)
        else $error("invalid input did not produce identity");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            int'(out_word.out_x) <= UNIT && int'(out_word.out_x) >= -UNIT &&
            int'(out_word.out_y) <= UNIT && int'(out_word.out_y) >= -UNIT &&
            int'(out_word.out_z) <= UNIT && int'(out_word.out_z) >= -UNIT &&
            int'(out_word.out_w) <= UNIT && int'(out_word.out_w) >= -UNIT)
        else $error("output component outside unit range");

    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("input accepted right after a configuration write");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
        else $error("input taken while the output word is stalled");

endmodule

bind quaternion_pose_retarget qpr_assertions u_qpr_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we)
);
